FILE: design/rar_pkg.sv
`default_nettype none
package rar_pkg;

    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERODEN = 2'd1,
        ST_DIVZERO = 2'd2
    } status_t;

    // classified job handed from front to back
    typedef struct packed {
        status_t     status;
        logic        add_sub;   // numerator is a sum or difference of two products
        logic        negate_q;
        logic [31:0] pa;        // product pairs: n0 = pa*pb, n1 = qa*qb, d = da*db
        logic [31:0] pb;
        logic [31:0] qa;
        logic [31:0] qb;
        logic [31:0] da;
        logic [31:0] db;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_SUM,
        BK_GCD,
        BK_DIVN,
        BK_DIVD,
        BK_OUT
    } back_state_t;

endpackage
`default_nettype wire

FILE: design/rar_front.sv
`default_nettype none
module rar_front #(
    parameter int DEPTH = rar_pkg::QueueDepth
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire  [1:0]       mode,
    input  wire  [31:0]      a_num,
    input  wire  [31:0]      a_den,
    input  wire  [31:0]      b_num,
    input  wire  [31:0]      b_den,
    output logic             job_valid,
    input  wire              job_ready,
    output rar_pkg::job_t    job
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rar_pkg::job_t q_mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    rar_pkg::job_t cls;
    logic push, pop;

    always_comb
    begin
        cls = '0;
        cls.status = rar_pkg::ST_OK;
        if (a_den == 32'd0 || b_den == 32'd0)
        begin
            cls.status = rar_pkg::ST_ZERODEN;
        end
        else if (mode == rar_pkg::MODE_DIV && b_num == 32'd0)
        begin
            cls.status = rar_pkg::ST_DIVZERO;
        end
        cls.da = a_den;
        cls.db = b_den;
        case (mode)
            rar_pkg::MODE_ADD, rar_pkg::MODE_SUB:
            begin
                cls.add_sub  = 1'b1;
                cls.negate_q = (mode == rar_pkg::MODE_SUB);
                cls.pa = a_num; cls.pb = b_den;
                cls.qa = b_num; cls.qb = a_den;
            end
            rar_pkg::MODE_MUL:
            begin
                cls.pa = a_num; cls.pb = b_num;
            end
            default:
            begin
                cls.pa = a_num; cls.pb = b_den;
                cls.db = b_num;
                cls.da = a_den;
            end
        endcase
    end

    assign in_ready  = (count_reg != CW'(DEPTH));
    assign push      = in_valid && in_ready;
    assign job_valid = (count_reg != '0);
    assign pop       = job_valid && job_ready;
    assign job       = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CW'(push) - CW'(pop);
        end
    end
endmodule
`default_nettype wire

FILE: design/rar_back.sv
`default_nettype none
module rar_back (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              job_valid,
    output logic             job_ready,
    input  rar_pkg::job_t    job,
    output logic             out_valid,
    input  wire              out_ready,
    output logic [63:0]      res_num,
    output logic [62:0]      res_den,
    output logic [1:0]       status
);
    rar_pkg::back_state_t state_reg, state_next;
    rar_pkg::job_t job_reg;
    logic signed [63:0] p_reg, q_reg, d_reg;
    logic nneg_reg, dneg_reg;
    logic [63:0] nmag_reg, dmag_reg;
    logic [63:0] ga_reg, gb_reg;       // Euclid operands
    // shared restoring divider: quotient/remainder over 64 steps
    logic [63:0] dv_q_reg, dv_r_reg, dv_div_reg;
    logic [6:0]  cnt_reg;
    logic        dv_run_reg;
    logic [64:0] trial;
    logic [64:0] sum65;
    logic signed [63:0] pm, qm, dm;
    logic [63:0] res_num_reg;
    logic [62:0] res_den_reg;
    logic [1:0]  status_reg;

    assign pm = $signed(job_reg.pa) * $signed(job_reg.pb);
    assign qm = $signed(job_reg.qa) * $signed(job_reg.qb);
    assign dm = $signed(job_reg.da) * $signed(job_reg.db);
    assign trial = {dv_r_reg, dv_q_reg[63]} - {1'b0, dv_div_reg};

    always_comb
    begin
        logic signed [64:0] qq;
        qq = job_reg.negate_q ? -{q_reg[63], q_reg} : {q_reg[63], q_reg};
        sum65 = {p_reg[63], p_reg} + qq;
    end

    assign job_ready = (state_reg == rar_pkg::BK_IDLE);
    assign out_valid = (state_reg == rar_pkg::BK_OUT);
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign status    = status_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rar_pkg::BK_IDLE: if (job_valid) state_next = rar_pkg::BK_MUL;
            rar_pkg::BK_MUL:
                state_next = (job_reg.status != rar_pkg::ST_OK) ? rar_pkg::BK_OUT
                                                                : rar_pkg::BK_SUM;
            rar_pkg::BK_SUM:
                state_next = (sum65 == '0) ? rar_pkg::BK_OUT : rar_pkg::BK_GCD;
            rar_pkg::BK_GCD:
                if (!dv_run_reg && gb_reg == '0) state_next = rar_pkg::BK_DIVN;
            rar_pkg::BK_DIVN:
                if (dv_run_reg && cnt_reg == 7'd0) state_next = rar_pkg::BK_DIVD;
            rar_pkg::BK_DIVD:
                if (dv_run_reg && cnt_reg == 7'd0) state_next = rar_pkg::BK_OUT;
            rar_pkg::BK_OUT: if (out_ready) state_next = rar_pkg::BK_IDLE;
            default: state_next = rar_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rar_pkg::BK_IDLE;
            dv_run_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                rar_pkg::BK_GCD, rar_pkg::BK_DIVN, rar_pkg::BK_DIVD:
                begin
                    if (!dv_run_reg)
                    begin
                        if (!(state_reg == rar_pkg::BK_GCD && gb_reg == '0))
                            dv_run_reg <= 1'b1;
                    end
                    else if (cnt_reg == 7'd0)
                    begin
                        dv_run_reg <= 1'b0;
                    end
                end
                default: dv_run_reg <= 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            rar_pkg::BK_IDLE:
            begin
                if (job_valid) job_reg <= job;
            end
            rar_pkg::BK_MUL:
            begin
                p_reg <= pm;
                q_reg <= job_reg.add_sub ? qm : 64'sd0;
                d_reg <= dm;
                status_reg  <= job_reg.status;
                res_num_reg <= '0;
                res_den_reg <= '0;
            end
            rar_pkg::BK_SUM:
            begin
                nneg_reg <= sum65[64];
                nmag_reg <= sum65[64] ? 64'(-sum65) : sum65[63:0];
                dneg_reg <= d_reg[63];
                dmag_reg <= d_reg[63] ? 64'(-d_reg) : d_reg;
                ga_reg   <= sum65[64] ? 64'(-sum65) : sum65[63:0];
                gb_reg   <= d_reg[63] ? 64'(-d_reg) : d_reg;
                res_num_reg <= '0;
                res_den_reg <= 63'd1;
            end
            rar_pkg::BK_GCD, rar_pkg::BK_DIVN, rar_pkg::BK_DIVD:
            begin
                if (!dv_run_reg)
                begin
                    // load divider: gcd step ga % gb, then nmag / g, then dmag / g
                    cnt_reg  <= 7'd63;
                    dv_r_reg <= '0;
                    if (state_reg == rar_pkg::BK_GCD)
                    begin
                        dv_q_reg <= ga_reg; dv_div_reg <= gb_reg;
                    end
                    else if (state_reg == rar_pkg::BK_DIVN)
                    begin
                        dv_q_reg <= nmag_reg; dv_div_reg <= ga_reg;
                    end
                    else
                    begin
                        dv_q_reg <= dmag_reg; dv_div_reg <= ga_reg;
                    end
                end
                else
                begin
                    cnt_reg <= cnt_reg - 7'd1;
                    if (!trial[64])
                    begin
                        dv_r_reg <= trial[63:0];
                        dv_q_reg <= {dv_q_reg[62:0], 1'b1};
                    end
                    else
                    begin
                        dv_r_reg <= {dv_r_reg[62:0], dv_q_reg[63]};
                        dv_q_reg <= {dv_q_reg[62:0], 1'b0};
                    end
                    if (cnt_reg == 7'd0)
                    begin
                        if (state_reg == rar_pkg::BK_GCD)
                        begin
                            ga_reg <= gb_reg;
                            gb_reg <= trial[64] ? {dv_r_reg[62:0], dv_q_reg[63]}
                                                : trial[63:0];
                        end
                        else if (state_reg == rar_pkg::BK_DIVN)
                        begin
                            logic [63:0] qn;
                            logic [63:0] mg;
                            qn = {dv_q_reg[62:0], ~trial[64]};
                            mg = qn[63] ? 64'h7FFF_FFFF_FFFF_FFFF : qn;
                            res_num_reg <= (nneg_reg != dneg_reg) ? -mg : mg;
                        end
                        else
                        begin
                            res_den_reg <= dv_q_reg[61:0] == '0 && trial[64]
                                ? 63'd0 : {dv_q_reg[61:0], ~trial[64]};
                        end
                    end
                end
            end
            default: ;
        endcase
    end
endmodule
`default_nettype wire

FILE: design/rational_arith_reduce_core.sv
`default_nettype none
// channel | dir | tdata (low bit up)                          | handshake
// s_axis  | in  | mode[1:0] a_num[33:2] a_den b_num b_den, pad | tvalid/tready
// m_axis  | out | res_num[63:0] res_den[126:64] status[128:127], pad | tvalid/tready
// One item at a time through the back end: setup (BK_MUL, BK_SUM), then the
// Euclid loop of remainder steps in one shared 64-step divider, then two
// divisions; a zero numerator or error skips the loop and the divisions.
// The front queue takes items while the back end works. Reset clears the
// queue and the sequencer; a stalled result holds until taken.
module rational_arith_reduce_core #(
    parameter int QUEUE_DEPTH = rar_pkg::QueueDepth
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [135:0] s_axis_tdata,   // mode, a_num, a_den, b_num, b_den
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [135:0] m_axis_tdata    // res_num, res_den, status
);
    logic          job_valid, job_ready;
    rar_pkg::job_t job;
    logic [63:0]   res_num;
    logic [62:0]   res_den;
    logic [1:0]    status;

    rar_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .mode(s_axis_tdata[1:0]), .a_num(s_axis_tdata[33:2]),
        .a_den(s_axis_tdata[65:34]), .b_num(s_axis_tdata[97:66]),
        .b_den(s_axis_tdata[129:98]),
        .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    rar_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(job_valid), .job_ready(job_ready), .job(job),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .res_num(res_num), .res_den(res_den), .status(status)
    );

    assign m_axis_tdata = {7'd0, status, res_den, res_num};
endmodule
`default_nettype wire

FILE: dv/rational_arith_reduce_core_tb.sv
`timescale 1ns / 1ps
module rational_arith_reduce_core_tb;

    localparam logic [63:0] MAX_MAG = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct {
        logic [63:0]      num;
        logic [62:0]      den;
        rar_pkg::status_t status;
    } fraction_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;

    fraction_t expected_fractions[$];
    int        mismatch_count;
    int        send_idle_pct;
    int        recv_stall_pct;

    rational_arith_reduce_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic fraction_t reduce_fraction(rar_pkg::mode_t op,
                                                  logic signed [31:0] an,
                                                  logic signed [31:0] ad,
                                                  logic signed [31:0] bn,
                                                  logic signed [31:0] bd);
        fraction_t         r;
        longint            p;
        longint            q;
        logic signed [65:0] n;
        logic signed [65:0] d;
        logic [65:0]       nm;
        logic [65:0]       dm;
        logic [63:0]       x;
        logic [63:0]       y;
        logic [63:0]       t;
        logic [63:0]       nq;
        logic [63:0]       dq;
        logic              nneg;
        logic              dneg;
        r.num = '0;
        r.den = '0;
        if (ad == 0 || bd == 0)
        begin
            r.status = rar_pkg::ST_ZERODEN;
            return r;
        end
        if (op == rar_pkg::MODE_DIV && bn == 0)
        begin
            r.status = rar_pkg::ST_DIVZERO;
            return r;
        end
        r.status = rar_pkg::ST_OK;
        case (op)
            rar_pkg::MODE_ADD, rar_pkg::MODE_SUB:
            begin
                p = longint'(an) * longint'(bd);
                q = longint'(bn) * longint'(ad);
                n = p;
                if (op == rar_pkg::MODE_SUB)
                    n = n - q;
                else
                    n = n + q;
                p = longint'(ad) * longint'(bd);
                d = p;
            end
            rar_pkg::MODE_MUL:
            begin
                p = longint'(an) * longint'(bn);
                q = longint'(ad) * longint'(bd);
                n = p;
                d = q;
            end
            default:
            begin
                p = longint'(an) * longint'(bd);
                q = longint'(ad) * longint'(bn);
                n = p;
                d = q;
            end
        endcase
        nneg = n < 0;
        dneg = d < 0;
        nm = nneg ? -n : n;
        dm = dneg ? -d : d;
        if (nm == 0)
        begin
            r.den = 63'd1;
            return r;
        end
        x = nm[63:0];
        y = dm[63:0];
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        nq = nm[63:0] / x;
        dq = dm[63:0] / x;
        if (nq > MAX_MAG)
            nq = MAX_MAG;
        r.num = (nneg != dneg) ? -nq : nq;
        r.den = dq[62:0];
        return r;
    endfunction

    task automatic send_op(rar_pkg::mode_t op, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tdata  <= {6'd0, bd, bn, ad, an, op};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_fractions.push_back(reduce_fraction(op, an, ad, bn, bd));
    endtask

    // mostly small magnitudes so the gcd actually cancels something
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            3, 4: return $urandom;
            5: return 32'($urandom_range(2000)) * 32'($urandom_range(2000));
            6: return -(32'($urandom_range(2000)) * 32'($urandom_range(2000)));
            7: return 32'sd1 << $urandom_range(31);
            default: return 32'($urandom_range(200)) - 32'd100;
        endcase
    endfunction

    task automatic test_directed();
        rar_pkg::mode_t op;
        op = rar_pkg::MODE_ADD;
        do
        begin
            send_op(op, 32'd3, 32'd0, 32'd1, 32'd2);
            send_op(op, 32'd3, 32'd4, 32'd1, 32'd0);
            send_op(op, 32'd0, 32'd7, 32'd0, -32'd5);
            send_op(op, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            send_op(op, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFF);
            op = op.next();
        end
        while (op != rar_pkg::MODE_ADD);
        send_op(rar_pkg::MODE_DIV, 32'd5, 32'd3, 32'd0, 32'd7);
        send_op(rar_pkg::MODE_DIV, 32'd0, 32'd0, 32'd0, 32'd0);
        send_op(rar_pkg::MODE_ADD, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
        send_op(rar_pkg::MODE_SUB, 32'd6, -32'd4, -32'd9, 32'd6);
        send_op(rar_pkg::MODE_MUL, -32'd1, -32'd1, 32'hFFFF_FFFF, 32'd1);
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            send_op(rar_pkg::mode_t'($urandom_range(3)), pick_operand(), pick_operand(),
                    pick_operand(), pick_operand());
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_fractions.size() == 0)
                begin
                    $error("result transaction with no expected fraction");
                    mismatch_count++;
                end
                else
                begin
                    fraction_t e;
                    e = expected_fractions.pop_front();
                    if (m_axis_tdata[63:0] !== e.num)
                    begin
                        $error("res_num expected %0d got %0d", $signed(e.num),
                               $signed(m_axis_tdata[63:0]));
                        mismatch_count++;
                    end
                    if (m_axis_tdata[126:64] !== e.den)
                    begin
                        $error("res_den expected %0d got %0d", e.den, m_axis_tdata[126:64]);
                        mismatch_count++;
                    end
                    if (m_axis_tdata[128:127] !== e.status)
                    begin
                        $error("status expected %0d got %0d", e.status,
                               m_axis_tdata[128:127]);
                        mismatch_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        mismatch_count = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(310, 12, 62);
        test_random(310, 62, 12);
        test_random(310, 0, 0);
        s_axis_tvalid <= 1'b0;
        wait (expected_fractions.size() == 0);
        repeat (200) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // worst case: ~93 Euclid steps, plus stalls, for every item
    initial
    begin
        #400_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
design/rar_pkg.sv
design/rar_front.sv
design/rar_back.sv
design/rational_arith_reduce_core.sv
dv/rational_arith_reduce_core_tb.sv
